/* design/oas_pkg.sv */
`default_nettype none

package oas_pkg;

    // field widths
    localparam int DIST_W     = 12;
    localparam int THR_W      = 12;
    localparam int TIME_W     = 20;
    localparam int AGE_W      = 16;
    localparam int MULT_W     = 8;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // comparison and product widths
    localparam int CMP_W  = (DIST_W > THR_W) ? DIST_W : THR_W;
    localparam int PROD_W = DIST_W + MULT_W;
    localparam int SAT_W  = (PROD_W > TIME_W) ? PROD_W : TIME_W + 1;

    // input tdata layout, lowest bit first
    localparam int IN_SELF_BIT   = 0;
    localparam int IN_SIGNAL_BIT = 1;
    localparam int IN_FRONT_LSB  = 2;
    localparam int IN_LEFT_LSB   = IN_FRONT_LSB + DIST_W;
    localparam int IN_RIGHT_LSB  = IN_LEFT_LSB + DIST_W;
    localparam int IN_AGE_LSB    = IN_RIGHT_LSB + DIST_W;
    localparam int IN_USED_W     = IN_AGE_LSB + AGE_W;
    localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_USED_W  = CMD_W + 1;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] TIME_MAX            = '1;
    localparam logic [TIME_W-1:0] INITIAL_REFRESH_AGE = TIME_W'(1000);

    // drive commands
    localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FORWARD    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TURN_RIGHT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TURN_LEFT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BEAR_RIGHT = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BEAR_LEFT  = 3'd6;

    // item kinds
    localparam logic ACTION_TICK   = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_COLLISION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_COLLISION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_WARNING    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_CLEAR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_TOL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_REFRESH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BEAR_MULT       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_MULT    = 3'd7;

    typedef struct packed {
        logic [THR_W-1:0]  front_collision_threshold;
        logic [THR_W-1:0]  side_collision_threshold;
        logic [THR_W-1:0]  side_warning_threshold;
        logic [THR_W-1:0]  side_clear_threshold;
        logic [THR_W-1:0]  centre_window;
        logic [TIME_W-1:0] turn_refresh_age;
        logic [MULT_W-1:0] bear_age_multiplier;
        logic [MULT_W-1:0] forward_age_multiplier;
    } oas_cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0] front;
        logic [DIST_W-1:0] left;
        logic [DIST_W-1:0] right;
    } oas_dist_t;

endpackage

`default_nettype wire

/* design/oas_decide.sv */
`default_nettype none

module oas_decide
(
    input  wire oas_pkg::oas_cfg_t                 cfg,
    input  wire oas_pkg::oas_dist_t                ranges,
    input  wire logic [oas_pkg::TIME_W-1:0]        refresh_limit,
    output logic [oas_pkg::CMD_W-1:0]              drive_command,
    output logic [oas_pkg::TIME_W-1:0]             refresh_limit_next
);

    logic [oas_pkg::CMP_W-1:0]  f;
    logic [oas_pkg::CMP_W-1:0]  l;
    logic [oas_pkg::CMP_W-1:0]  r;
    logic [oas_pkg::CMP_W-1:0]  front_thr;
    logic [oas_pkg::CMP_W-1:0]  coll_thr;
    logic [oas_pkg::CMP_W-1:0]  warn_thr;
    logic [oas_pkg::CMP_W-1:0]  clear_thr;
    logic [oas_pkg::CMP_W-1:0]  tol;
    logic [oas_pkg::CMP_W-1:0]  diff;
    logic                       keep_limit;
    logic                       use_turn_age;
    logic [oas_pkg::DIST_W-1:0] mult_dist;
    logic [oas_pkg::MULT_W-1:0] mult_k;
    logic [oas_pkg::PROD_W-1:0] prod;
    logic [oas_pkg::SAT_W-1:0]  prod_ext;
    logic [oas_pkg::TIME_W-1:0] prod_sat;

    // common width for all compares
    assign f         = oas_pkg::CMP_W'(ranges.front);
    assign l         = oas_pkg::CMP_W'(ranges.left);
    assign r         = oas_pkg::CMP_W'(ranges.right);
    assign front_thr = oas_pkg::CMP_W'(cfg.front_collision_threshold);
    assign coll_thr  = oas_pkg::CMP_W'(cfg.side_collision_threshold);
    assign warn_thr  = oas_pkg::CMP_W'(cfg.side_warning_threshold);
    assign clear_thr = oas_pkg::CMP_W'(cfg.side_clear_threshold);
    assign tol       = oas_pkg::CMP_W'(cfg.centre_window);
    assign diff      = (l > r) ? (l - r) : (r - l);

    // priority decision, also picks the multiplier operands
    always_comb
    begin
        drive_command = oas_pkg::CMD_STOP;
        keep_limit    = 1'b0;
        use_turn_age  = 1'b0;
        mult_dist     = ranges.right;
        mult_k        = cfg.bear_age_multiplier;
        if (l <= coll_thr && r <= coll_thr)
        begin
            // trapped on both sides
            drive_command = oas_pkg::CMD_STOP;
            keep_limit    = 1'b1;
        end
        else if (f <= front_thr)
        begin
            drive_command = (l > r) ? oas_pkg::CMD_TURN_LEFT : oas_pkg::CMD_TURN_RIGHT;
            use_turn_age  = 1'b1;
        end
        else if (l < coll_thr)
        begin
            drive_command = oas_pkg::CMD_TURN_RIGHT;
            use_turn_age  = 1'b1;
        end
        else if (r < coll_thr)
        begin
            drive_command = oas_pkg::CMD_TURN_LEFT;
            use_turn_age  = 1'b1;
        end
        else if (l < warn_thr)
        begin
            drive_command = oas_pkg::CMD_BEAR_RIGHT;
            mult_dist     = ranges.left;
        end
        else if (r < warn_thr)
        begin
            drive_command = oas_pkg::CMD_BEAR_LEFT;
            mult_dist     = ranges.right;
        end
        else if (diff < tol || l > clear_thr || r > clear_thr)
        begin
            drive_command = oas_pkg::CMD_FORWARD;
            mult_dist     = ranges.front;
            mult_k        = cfg.forward_age_multiplier;
        end
        else if (l < r)
        begin
            drive_command = oas_pkg::CMD_BEAR_RIGHT;
            mult_dist     = ranges.left;
        end
        else
        begin
            drive_command = oas_pkg::CMD_BEAR_LEFT;
            mult_dist     = ranges.right;
        end
    end

    // refresh limit product, saturated to the counter width
    assign prod     = oas_pkg::PROD_W'(mult_dist) * oas_pkg::PROD_W'(mult_k);
    assign prod_ext = oas_pkg::SAT_W'(prod);
    assign prod_sat = (prod_ext > oas_pkg::SAT_W'(oas_pkg::TIME_MAX))
                    ? oas_pkg::TIME_MAX : prod_ext[oas_pkg::TIME_W-1:0];

    always_comb
    begin
        if (keep_limit)
        begin
            refresh_limit_next = refresh_limit;
        end
        else if (use_turn_age)
        begin
            refresh_limit_next = cfg.turn_refresh_age;
        end
        else
        begin
            refresh_limit_next = prod_sat;
        end
    end

endmodule

`default_nettype wire

/* design/obstacle_avoid_steering_top.sv */
// Obstacle avoidance steering. Each input transaction is either a 1 ms tick
// (tuser 0) or a fresh front/left/right range sample (tuser 1), and each gives
// exactly one output transaction with a drive command and a sample request.
// The item passes an input register and one stage of compare logic plus a
// 12x8 multiplier into the result register, and a new transaction is taken
// every cycle while the output side keeps up; the elapsed/limit state is
// updated in that same stage, which is what lets consecutive items follow
// without a gap. Configuration writes are always ready and are meant to
// happen while no transaction is in flight.
`default_nettype none

module obstacle_avoid_steering_top
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // self_drive, obstacle_signal, front_distance, left_distance,
    // right_distance, sample_age, zero pad
    input  wire logic [oas_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // action
    input  wire logic                              s_axis_tuser,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // drive_command, request_sample, zero pad
    output logic [oas_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [oas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [oas_pkg::CFG_DATA_W-1:0]    cfg_data
);

    oas_pkg::oas_cfg_t           cfg_reg;

    logic                        in_valid_reg;
    logic                        in_action_reg;
    logic                        in_self_reg;
    logic                        in_signal_reg;
    oas_pkg::oas_dist_t          in_dist_reg;
    logic [oas_pkg::AGE_W-1:0]   in_age_reg;

    oas_pkg::oas_dist_t          stored_dist_reg;
    logic [oas_pkg::AGE_W-1:0]   stored_age_reg;
    logic [oas_pkg::TIME_W-1:0]  elapsed_reg;
    logic [oas_pkg::TIME_W-1:0]  refresh_limit_reg;
    logic                        awaiting_reg;

    oas_pkg::oas_dist_t          stored_dist_next;
    logic [oas_pkg::AGE_W-1:0]   stored_age_next;
    logic [oas_pkg::TIME_W-1:0]  elapsed_next;
    logic [oas_pkg::TIME_W-1:0]  refresh_limit_next;
    logic                        awaiting_next;

    logic                        out_valid_reg;
    logic [oas_pkg::CMD_W-1:0]   out_cmd_reg;
    logic                        out_req_reg;
    logic [oas_pkg::CMD_W-1:0]   out_cmd_next;
    logic                        out_req_next;

    logic                        advance;
    logic                        in_accept;
    logic [oas_pkg::TIME_W-1:0]  elapsed_inc;
    logic [oas_pkg::TIME_W:0]    total;
    logic [oas_pkg::CMD_W-1:0]   dec_cmd;
    logic [oas_pkg::TIME_W-1:0]  dec_limit;

    // handshake
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.front_collision_threshold <= oas_pkg::THR_W'(30);
            cfg_reg.side_collision_threshold  <= oas_pkg::THR_W'(10);
            cfg_reg.side_warning_threshold    <= oas_pkg::THR_W'(20);
            cfg_reg.side_clear_threshold      <= oas_pkg::THR_W'(50);
            cfg_reg.centre_window             <= oas_pkg::THR_W'(5);
            cfg_reg.turn_refresh_age          <= oas_pkg::TIME_W'(200);
            cfg_reg.bear_age_multiplier       <= oas_pkg::MULT_W'(10);
            cfg_reg.forward_age_multiplier    <= oas_pkg::MULT_W'(10);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                oas_pkg::REG_FRONT_COLLISION:
                    cfg_reg.front_collision_threshold <= cfg_data[oas_pkg::THR_W-1:0];
                oas_pkg::REG_SIDE_COLLISION:
                    cfg_reg.side_collision_threshold <= cfg_data[oas_pkg::THR_W-1:0];
                oas_pkg::REG_SIDE_WARNING:
                    cfg_reg.side_warning_threshold <= cfg_data[oas_pkg::THR_W-1:0];
                oas_pkg::REG_SIDE_CLEAR:
                    cfg_reg.side_clear_threshold <= cfg_data[oas_pkg::THR_W-1:0];
                oas_pkg::REG_CENTER_TOL:
                    cfg_reg.centre_window <= cfg_data[oas_pkg::THR_W-1:0];
                oas_pkg::REG_TURN_REFRESH:
                    cfg_reg.turn_refresh_age <= cfg_data[oas_pkg::TIME_W-1:0];
                oas_pkg::REG_BEAR_MULT:
                    cfg_reg.bear_age_multiplier <= cfg_data[oas_pkg::MULT_W-1:0];
                oas_pkg::REG_FORWARD_MULT:
                    cfg_reg.forward_age_multiplier <= cfg_data[oas_pkg::MULT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_action_reg     <= s_axis_tuser;
            in_self_reg       <= s_axis_tdata[oas_pkg::IN_SELF_BIT];
            in_signal_reg     <= s_axis_tdata[oas_pkg::IN_SIGNAL_BIT];
            in_dist_reg.front <= s_axis_tdata[oas_pkg::IN_FRONT_LSB +: oas_pkg::DIST_W];
            in_dist_reg.left  <= s_axis_tdata[oas_pkg::IN_LEFT_LSB +: oas_pkg::DIST_W];
            in_dist_reg.right <= s_axis_tdata[oas_pkg::IN_RIGHT_LSB +: oas_pkg::DIST_W];
            in_age_reg        <= s_axis_tdata[oas_pkg::IN_AGE_LSB +: oas_pkg::AGE_W];
        end
    end

    // steering decision on the freshly stored sample
    oas_decide u_decide
    (
        .cfg                (cfg_reg),
        .ranges             (in_dist_reg),
        .refresh_limit      (refresh_limit_reg),
        .drive_command      (dec_cmd),
        .refresh_limit_next (dec_limit)
    );

    // tick bookkeeping
    assign elapsed_inc = (elapsed_reg < oas_pkg::TIME_MAX)
                       ? elapsed_reg + oas_pkg::TIME_W'(1) : elapsed_reg;
    assign total       = (oas_pkg::TIME_W + 1)'(elapsed_inc)
                       + (oas_pkg::TIME_W + 1)'(stored_age_reg);

    // next state and result for the item in the input register
    always_comb
    begin
        stored_dist_next   = stored_dist_reg;
        stored_age_next    = stored_age_reg;
        elapsed_next       = elapsed_reg;
        refresh_limit_next = refresh_limit_reg;
        awaiting_next      = awaiting_reg;
        out_cmd_next       = oas_pkg::CMD_NONE;
        out_req_next       = 1'b0;
        if (in_action_reg == oas_pkg::ACTION_SAMPLE)
        begin
            stored_dist_next = in_dist_reg;
            stored_age_next  = in_age_reg;
            elapsed_next     = '0;
            awaiting_next    = 1'b0;
            if (in_self_reg)
            begin
                out_cmd_next       = dec_cmd;
                refresh_limit_next = dec_limit;
            end
        end
        else
        begin
            elapsed_next = elapsed_inc;
            if (in_self_reg && (awaiting_reg || in_signal_reg
                || total > (oas_pkg::TIME_W + 1)'(refresh_limit_reg)))
            begin
                out_cmd_next  = oas_pkg::CMD_STOP;
                out_req_next  = 1'b1;
                awaiting_next = 1'b1;
            end
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_dist_reg   <= '0;
            stored_age_reg    <= '0;
            elapsed_reg       <= '0;
            refresh_limit_reg <= oas_pkg::INITIAL_REFRESH_AGE;
            awaiting_reg      <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                stored_dist_reg   <= stored_dist_next;
                stored_age_reg    <= stored_age_next;
                elapsed_reg       <= elapsed_next;
                refresh_limit_reg <= refresh_limit_next;
                awaiting_reg      <= awaiting_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_cmd_reg <= out_cmd_next;
            out_req_reg <= out_req_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = oas_pkg::OUT_TDATA_W'({out_req_reg, out_cmd_reg});

endmodule

`default_nettype wire
